// ===== rtl/rmt_pkg.sv =====
// Shared types and constants for the recursive mutex table.
package rmt_pkg;

   // Fixed field widths of the request and response streams
   localparam int unsigned REQ_TYPE_W  = 2;
   localparam int unsigned INDEX_W     = 3;
   localparam int unsigned THREAD_W    = 8;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned SLOT_OUT_W  = 3;
   localparam int unsigned OWNER_OUT_W = 8;
   localparam int unsigned COUNT_OUT_W = 16;

   // Packed stream widths, padded to whole bytes
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 32;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_CREATE  = 2'd0,
      REQ_ACQUIRE = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_DELETE  = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_SLOT   = 3'd1,
      ST_BUSY       = 3'd2,
      ST_NO_FREE    = 3'd3,
      ST_COUNT_FULL = 3'd4
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // capture the request fields
      logic execute;    // table read-modify-write, load the response register
   } rmt_cmd_type;

endpackage

// ===== rtl/rmt_ctrl.sv =====
// Controller: request/response handshake and sequencing of the table update.
module rmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output rmt_pkg::rmt_cmd_type cmd
);

   rmt_pkg::ctl_state_type state_ff;
   rmt_pkg::ctl_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmt_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rmt_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = rmt_pkg::CTL_EXEC;
            end
         end
         rmt_pkg::CTL_EXEC: begin
            // wait for the response register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.execute = 1'b1;
               state_in    = rmt_pkg::CTL_IDLE;
            end
         end
         default: state_in = rmt_pkg::CTL_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && state_ff == rmt_pkg::CTL_EXEC))
      else $error("request accepted but controller did not move to execute");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("execute did not produce a response");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("response appeared without an execute");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending response overwritten");

endmodule

// ===== rtl/rmt_datapath.sv =====
// Datapath: request register, mutex slot table and response register.
module rmt_datapath #(
   parameter int unsigned MUTEX_SLOTS    = 8,
   parameter int unsigned THREAD_ID_BITS = 8,
   parameter int unsigned COUNT_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmt_pkg::rmt_cmd_type                 cmd,
   input  logic [rmt_pkg::REQ_TYPE_W-1:0]       req_type,
   input  logic [rmt_pkg::INDEX_W-1:0]          mutex_index,
   input  logic [rmt_pkg::THREAD_W-1:0]         thread_id,
   input  logic                                 want_recursive,
   output logic [rmt_pkg::STATUS_W-1:0]         status,
   output logic [rmt_pkg::SLOT_OUT_W-1:0]       slot_out,
   output logic                                 owner_valid,
   output logic [rmt_pkg::OWNER_OUT_W-1:0]      owner_out,
   output logic [rmt_pkg::COUNT_OUT_W-1:0]      count_out
);

   localparam int unsigned SLOT_BITS = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
   localparam int unsigned USED_W    = SLOT_BITS + 1;
   localparam int unsigned IDX_EXT_W =
      ((SLOT_BITS > rmt_pkg::INDEX_W) ? SLOT_BITS : rmt_pkg::INDEX_W) + 1;

   // request register
   rmt_pkg::req_kind_type               kind_ff;
   logic [rmt_pkg::INDEX_W-1:0]         index_ff;
   logic [THREAD_ID_BITS-1:0]           tid_ff;
   logic                                want_rec_ff;

   // slot table
   logic [USED_W-1:0]                   used_ff;
   logic [MUTEX_SLOTS-1:0]              active_ff;
   logic [MUTEX_SLOTS-1:0]              rec_ff;
   logic [MUTEX_SLOTS-1:0]              held_ff;
   logic [THREAD_ID_BITS-1:0]           owner_ff [MUTEX_SLOTS];
   logic [COUNT_BITS-1:0]               count_ff [MUTEX_SLOTS];

   // response register
   logic [rmt_pkg::STATUS_W-1:0]        status_ff;
   logic [rmt_pkg::SLOT_OUT_W-1:0]      slot_ff;
   logic                                valid_ff;
   logic [rmt_pkg::OWNER_OUT_W-1:0]     owner_out_ff;
   logic [rmt_pkg::COUNT_OUT_W-1:0]     count_out_ff;

   // update logic
   logic [IDX_EXT_W-1:0]                idx_ext;
   logic                                in_range;
   logic                                table_full;
   logic [SLOT_BITS-1:0]                sel;
   logic                                cur_active;
   logic                                cur_rec;
   logic                                cur_held;
   logic [THREAD_ID_BITS-1:0]           cur_owner;
   logic [COUNT_BITS-1:0]               cur_count;
   logic                                wr_en;
   logic                                used_inc;
   logic                                active_in;
   logic                                rec_in;
   logic                                held_in;
   logic [THREAD_ID_BITS-1:0]           owner_in;
   logic [COUNT_BITS-1:0]               count_in;
   logic [COUNT_BITS-1:0]               count_dec;
   rmt_pkg::status_type                 status_in;
   logic [rmt_pkg::SLOT_OUT_W-1:0]      slot_in;
   logic                                valid_in;
   logic [31:0]                         owner_wide;
   logic [31:0]                         count_wide;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff     <= rmt_pkg::req_kind_type'(req_type);
         index_ff    <= mutex_index;
         tid_ff      <= THREAD_ID_BITS'(thread_id);
         want_rec_ff <= want_recursive;
      end
   end

   assign idx_ext    = IDX_EXT_W'(index_ff);
   assign in_range   = idx_ext < IDX_EXT_W'(MUTEX_SLOTS);
   assign table_full = used_ff == USED_W'(MUTEX_SLOTS);
   assign sel        = (kind_ff == rmt_pkg::REQ_CREATE) ? used_ff[SLOT_BITS-1:0]
                                                        : idx_ext[SLOT_BITS-1:0];

   assign cur_active = active_ff[sel];
   assign cur_rec    = rec_ff[sel];
   assign cur_held   = held_ff[sel];
   assign cur_owner  = owner_ff[sel];
   assign cur_count  = count_ff[sel];
   assign count_dec  = (cur_count != '0) ? (cur_count - COUNT_BITS'(1)) : cur_count;

   always_comb begin
      wr_en     = 1'b0;
      used_inc  = 1'b0;
      active_in = cur_active;
      rec_in    = cur_rec;
      held_in   = cur_held;
      owner_in  = cur_owner;
      count_in  = cur_count;
      status_in = rmt_pkg::ST_OK;
      slot_in   = index_ff;
      valid_in  = 1'b0;
      if (kind_ff == rmt_pkg::REQ_CREATE) begin
         if (table_full) begin
            status_in = rmt_pkg::ST_NO_FREE;
            slot_in   = '0;
         end else begin
            wr_en     = 1'b1;
            used_inc  = 1'b1;
            active_in = 1'b1;
            rec_in    = want_rec_ff;
            held_in   = 1'b0;
            owner_in  = '0;
            count_in  = '0;
            slot_in   = rmt_pkg::SLOT_OUT_W'(used_ff);
         end
      end else if (!in_range || !cur_active) begin
         status_in = rmt_pkg::ST_BAD_SLOT;
      end else begin
         unique case (kind_ff)
            rmt_pkg::REQ_ACQUIRE: begin
               if (!cur_held) begin
                  wr_en    = 1'b1;
                  held_in  = 1'b1;
                  owner_in = tid_ff;
                  count_in = COUNT_BITS'(1);
               end else if (cur_owner == tid_ff && cur_rec) begin
                  if (cur_count == '1) begin
                     status_in = rmt_pkg::ST_COUNT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = cur_count + COUNT_BITS'(1);
                  end
               end else begin
                  status_in = rmt_pkg::ST_BUSY;
               end
            end
            rmt_pkg::REQ_RELEASE: begin
               if (!cur_held || cur_owner != tid_ff) begin
                  status_in = rmt_pkg::ST_BUSY;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_dec;
                  if (count_dec == '0) begin
                     held_in  = 1'b0;
                     owner_in = '0;
                  end
               end
            end
            rmt_pkg::REQ_DELETE: begin
               wr_en     = 1'b1;
               active_in = 1'b0;
               held_in   = 1'b0;
               count_in  = '0;
            end
            default: begin
               status_in = rmt_pkg::ST_BAD_SLOT;
            end
         endcase
         valid_in = active_in && held_in;
      end
   end

   assign owner_wide = valid_in ? 32'(owner_in) : '0;
   assign count_wide = valid_in ? 32'(count_in) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         active_ff <= '0;
         rec_ff    <= '0;
         held_ff   <= '0;
         for (int i = 0; i < MUTEX_SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         if (used_inc) begin
            used_ff <= used_ff + USED_W'(1);
         end
         if (wr_en) begin
            active_ff[sel] <= active_in;
            rec_ff[sel]    <= rec_in;
            held_ff[sel]   <= held_in;
            count_ff[sel]  <= count_in;
         end
      end
   end

   // owner is only read while the slot is held, so it needs no reset
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         owner_ff[sel] <= owner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff    <= status_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         owner_out_ff <= owner_wide[rmt_pkg::OWNER_OUT_W-1:0];
         count_out_ff <= count_wide[rmt_pkg::COUNT_OUT_W-1:0];
      end
   end

   assign status      = status_ff;
   assign slot_out    = slot_ff;
   assign owner_valid = valid_ff;
   assign owner_out   = owner_out_ff;
   assign count_out   = count_out_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(MUTEX_SLOTS))
      else $error("more slots created than the table holds");

   a_held_active: assert property (@(posedge clock) disable iff (reset)
      (held_ff & ~active_ff) == '0)
      else $error("lock held on an inactive slot");

   a_create_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && kind_ff == rmt_pkg::REQ_CREATE && !table_full)
      |=> used_ff == $past(used_ff) + USED_W'(1))
      else $error("create did not advance the slot count");

endmodule

// ===== rtl/recursive_mutex_table.sv =====
// Top level of the recursive mutex table: stream ports, controller and datapath.
//
//   channel  direction  payload                                        handshake
//   req_     in         tuser: kind; tdata: slot, thread, recursive    tvalid/tready
//   rsp_     out        tdata: status, slot, owner valid/id, count     tvalid/tready
//
// Each request is captured, then the execute state does the read-modify-write
// of the addressed slot in the table, which loads the response register.
// A new request is taken while the previous response still waits in that register;
// the update step waits only if that response has not been taken by then.
// A stalled response holds its value. Reset is synchronous and clears the
// handshake state, the slot count and the active, recursive, held and count fields
// of every slot in the same cycle; there is no clearing pass.
module recursive_mutex_table #(
   parameter int unsigned MUTEX_SLOTS    = 8,
   parameter int unsigned THREAD_ID_BITS = 8,
   parameter int unsigned COUNT_BITS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_type
   input  logic [rmt_pkg::REQ_TYPE_W-1:0]    req_tuser,
   // mutex_index [2:0], thread_id [10:3], want_recursive [11], zero pad [15:12]
   input  logic [rmt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [2:0], slot_out [5:3], owner_valid [6], owner_out [14:7],
   // count_out [30:15], zero pad [31]
   output logic [rmt_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   rmt_pkg::rmt_cmd_type                cmd;
   logic [rmt_pkg::STATUS_W-1:0]        status;
   logic [rmt_pkg::SLOT_OUT_W-1:0]      slot_out;
   logic                                owner_valid;
   logic [rmt_pkg::OWNER_OUT_W-1:0]     owner_out;
   logic [rmt_pkg::COUNT_OUT_W-1:0]     count_out;

   rmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rmt_datapath #(
      .MUTEX_SLOTS    (MUTEX_SLOTS),
      .THREAD_ID_BITS (THREAD_ID_BITS),
      .COUNT_BITS     (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_tuser),
      .mutex_index    (req_tdata[2:0]),
      .thread_id      (req_tdata[10:3]),
      .want_recursive (req_tdata[11]),
      .status         (status),
      .slot_out       (slot_out),
      .owner_valid    (owner_valid),
      .owner_out      (owner_out),
      .count_out      (count_out)
   );

   assign rsp_tdata = {1'b0, count_out, owner_out, owner_valid, slot_out, status};

endmodule
